// File: hw/rtl/cfwd_pkg.sv
// Shared types, constants and ring position helpers for the command FIFO.
`default_nettype none

package cfwd_pkg;

    // Ring geometry and command size limit
    localparam int CAPACITY    = 64;
    localparam int MAX_COMMAND = 64;

    localparam int PTR_W  = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int DATA_W = 8;
    localparam int LEN_W  = 7;
    localparam int STAT_W = 3;

    // Operation codes carried by func
    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 3'd0,
        ST_REPEAT = 3'd1,
        ST_FULL   = 3'd2,
        ST_EMPTY  = 3'd3,
        ST_SHORT  = 3'd4,
        ST_TRUNC  = 3'd5
    } status_t;

    // Classified item handed from the front to the back
    typedef struct packed {
        logic              is_pop;
        logic              is_term;
        logic [DATA_W-1:0] data;
        logic [LEN_W-1:0]  size;
    } cmd_t;

    // Next ring position with wrap
    function automatic logic [PTR_W-1:0] pos_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(CAPACITY - 1)) ? '0 : p + 1'b1;
    endfunction

    // Previous ring position with wrap
    function automatic logic [PTR_W-1:0] pos_dec(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_W'(CAPACITY - 1) : p - 1'b1;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/command_fifo_with_overflow_drop.sv
// Top level of the command FIFO with drop on overflow.
//
// Command channel: an item (func, byte_in, max_len) is taken at a rising edge
// with start high and busy low. func 0 pushes byte_in into a 64-byte ring of
// zero-terminated commands; func 1 pops one command, at most max_len bytes
// (one byte if max_len is 0). Result channel: each result shows on
// byte_out/byte_valid/status/last for one cycle with strobe high; last marks
// the final result of an item. The receiver cannot stall, so results are
// never held back. With the back end idle, an accepted push is stored in the
// queue, then taken by the back end, which registers its result. A push that
// finds the ring full rewinds one byte per cycle to the last stored terminator
// or an empty ring before its result appears. A pop starts the ring read, then
// takes one byte per cycle, emitted or discarded; an empty marker ends it if
// the ring runs dry before a terminator or the limit. Pushes go at one per
// cycle while no pop or rewind runs; the ring's single read port sets the
// one-byte-per-cycle pace of pops and rewinds. A two-item queue between
// front and back absorbs items while a pop runs; busy is high when it is full.
// Reset: ring empty, no command pending, first pushed terminator refused.
`default_nettype none

module command_fifo_with_overflow_drop (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic                           func,
    input  wire logic [cfwd_pkg::DATA_W-1:0]    byte_in,
    input  wire logic [cfwd_pkg::LEN_W-1:0]     max_len,
    output logic                                strobe,
    output logic [cfwd_pkg::DATA_W-1:0]         byte_out,
    output logic                                byte_valid,
    output logic [cfwd_pkg::STAT_W-1:0]         status,
    output logic                                last
);
    import cfwd_pkg::*;

    cmd_t head;
    logic head_valid;
    logic deq;

    cfwd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .func       (func),
        .byte_in    (byte_in),
        .max_len    (max_len),
        .busy       (busy),
        .head       (head),
        .head_valid (head_valid),
        .deq        (deq)
    );

    cfwd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .deq        (deq),
        .strobe     (strobe),
        .byte_out   (byte_out),
        .byte_valid (byte_valid),
        .status     (status),
        .last       (last)
    );

endmodule

`default_nettype wire

// File: hw/rtl/cfwd_front.sv
// Front end: accepts items, classifies them and queues them for the back end.
`default_nettype none

module cfwd_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic                           func,
    input  wire logic [cfwd_pkg::DATA_W-1:0]    byte_in,
    input  wire logic [cfwd_pkg::LEN_W-1:0]     max_len,
    output logic                                busy,
    output cfwd_pkg::cmd_t                      head,
    output logic                                head_valid,
    input  wire logic                           deq
);
    import cfwd_pkg::*;

    cmd_t        q_reg [2];
    logic        wp_reg;
    logic        wp_next;
    logic        rp_reg;
    logic        rp_next;
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    logic        accept;
    logic        take;
    cmd_t        cls;

    // Classify: terminator flag, pop flag, saturated pop length
    always_comb
    begin
        cls.is_pop  = (func == FUNC_POP);
        cls.is_term = (byte_in == '0);
        cls.data    = byte_in;
        cls.size    = (max_len > LEN_W'(MAX_COMMAND)) ? LEN_W'(MAX_COMMAND) : max_len;
    end

    assign busy       = (cnt_reg == 2'd2);
    assign accept     = start && !busy;
    assign head_valid = (cnt_reg != 2'd0);
    assign head       = q_reg[rp_reg];
    assign take       = deq && head_valid;

    // Queue pointers and occupancy
    always_comb
    begin
        wp_next  = accept ? ~wp_reg : wp_reg;
        rp_next  = take ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg;
        if (accept && !take)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (take && !accept)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // Queue entries
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_reg[wp_reg] <= cls;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/cfwd_back.sv
// Back end: byte ring, push/rewind handling and pop sequencing with results.
`default_nettype none

module cfwd_back (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire cfwd_pkg::cmd_t                 head,
    input  wire logic                           head_valid,
    output logic                                deq,
    output logic                                strobe,
    output logic [cfwd_pkg::DATA_W-1:0]         byte_out,
    output logic                                byte_valid,
    output logic [cfwd_pkg::STAT_W-1:0]         status,
    output logic                                last
);
    import cfwd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_DISC,
        S_EMPTY,
        S_RW
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [PTR_W-1:0]   rd_pos_reg;
    logic [PTR_W-1:0]   rd_pos_next;
    logic [PTR_W-1:0]   wr_pos_reg;
    logic [PTR_W-1:0]   wr_pos_next;
    logic [CNT_W-1:0]   fill_reg;
    logic [CNT_W-1:0]   fill_next;
    logic               dropping_reg;
    logic               dropping_next;
    logic               lwt_reg;
    logic               lwt_next;
    logic [LEN_W-1:0]   idx_reg;
    logic [LEN_W-1:0]   idx_next;
    logic [LEN_W-1:0]   size_reg;
    logic [LEN_W-1:0]   size_next;
    logic               strobe_reg;
    logic               strobe_next;
    logic [DATA_W-1:0]  bout_reg;
    logic [DATA_W-1:0]  bout_next;
    logic               bvalid_reg;
    logic               bvalid_next;
    status_t            status_reg;
    status_t            status_next;
    logic               last_reg;
    logic               last_next;

    logic [DATA_W-1:0]  mem [CAPACITY];
    logic [DATA_W-1:0]  rdata_reg;
    logic [PTR_W-1:0]   raddr;
    logic               mem_we;
    logic               use_rd;

    logic [DATA_W-1:0]  d;
    logic [CNT_W-1:0]   fill_dec;
    logic               d_nz;
    logic               first;
    logic               below;
    logic               cont;
    logic               disc;

    assign d        = rdata_reg;
    assign d_nz     = (d != '0);
    assign fill_dec = fill_reg - 1'b1;
    assign first    = (idx_reg == LEN_W'(1));
    assign below    = (idx_reg < size_reg);
    // Keep going while inside the command and under the limit
    assign cont     = d_nz && below;
    // Limit hit on a non-terminator after the first byte: drain the rest
    assign disc     = !first && d_nz && (idx_reg == size_reg);

    always_comb
    begin
        state_next    = state_reg;
        rd_pos_next   = rd_pos_reg;
        wr_pos_next   = wr_pos_reg;
        fill_next     = fill_reg;
        dropping_next = dropping_reg;
        lwt_next      = lwt_reg;
        idx_next      = idx_reg;
        size_next     = size_reg;
        strobe_next   = 1'b0;
        bout_next     = '0;
        bvalid_next   = 1'b0;
        status_next   = ST_OK;
        last_next     = 1'b0;
        mem_we        = 1'b0;
        deq           = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (head_valid)
                begin
                    deq = 1'b1;
                    if (head.is_pop)
                    begin
                        if (fill_reg == '0)
                        begin
                            strobe_next = 1'b1;
                            status_next = ST_EMPTY;
                            last_next   = 1'b1;
                        end
                        else
                        begin
                            state_next = S_POP;
                            idx_next   = LEN_W'(1);
                            size_next  = head.size;
                        end
                    end
                    else
                    begin
                        strobe_next = 1'b1;
                        last_next   = 1'b1;
                        if (dropping_reg && head.is_term)
                        begin
                            dropping_next = 1'b0;
                        end
                        else if (lwt_reg && head.is_term)
                        begin
                            status_next = ST_REPEAT;
                        end
                        else if (dropping_reg)
                        begin
                            status_next = ST_FULL;
                        end
                        else if (fill_reg != CNT_W'(CAPACITY))
                        begin
                            mem_we      = 1'b1;
                            wr_pos_next = pos_inc(wr_pos_reg);
                            fill_next   = fill_reg + 1'b1;
                            lwt_next    = head.is_term;
                        end
                        else
                        begin
                            // Full: rewind to the last stored terminator
                            dropping_next = 1'b1;
                            lwt_next      = 1'b1;
                            strobe_next   = 1'b0;
                            last_next     = 1'b0;
                            state_next    = S_RW;
                        end
                    end
                end
            end

            S_RW:
            begin
                if ((fill_reg == '0) || !d_nz)
                begin
                    strobe_next = 1'b1;
                    status_next = ST_FULL;
                    last_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    wr_pos_next = pos_dec(wr_pos_reg);
                    fill_next   = fill_dec;
                end
            end

            S_POP:
            begin
                rd_pos_next = pos_inc(rd_pos_reg);
                fill_next   = fill_dec;
                if (cont)
                begin
                    strobe_next = 1'b1;
                    bout_next   = d;
                    bvalid_next = 1'b1;
                    idx_next    = idx_reg + 1'b1;
                    if (fill_dec == '0)
                    begin
                        state_next = S_EMPTY;
                    end
                end
                else if (disc)
                begin
                    if (fill_dec == '0)
                    begin
                        strobe_next = 1'b1;
                        bout_next   = d;
                        bvalid_next = 1'b1;
                        status_next = ST_TRUNC;
                        last_next   = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_DISC;
                    end
                end
                else
                begin
                    // Terminator before the limit and after the first byte gives short status, else plain end
                    strobe_next = 1'b1;
                    bout_next   = d;
                    bvalid_next = 1'b1;
                    status_next = (!d_nz && below && !first) ? ST_SHORT : ST_OK;
                    last_next   = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            S_DISC:
            begin
                rd_pos_next = pos_inc(rd_pos_reg);
                fill_next   = fill_dec;
                if (!d_nz || (fill_dec == '0))
                begin
                    strobe_next = 1'b1;
                    bout_next   = d;
                    bvalid_next = 1'b1;
                    status_next = ST_TRUNC;
                    last_next   = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            S_EMPTY:
            begin
                strobe_next = 1'b1;
                status_next = ST_EMPTY;
                last_next   = 1'b1;
                state_next  = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Read address: next read position for pops, byte before write position for rewind
    assign use_rd = (state_reg == S_POP) || (state_reg == S_DISC) ||
                    ((state_reg == S_IDLE) && head.is_pop);
    assign raddr  = use_rd ? rd_pos_next : pos_dec(wr_pos_next);

    // State and registered results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            rd_pos_reg   <= '0;
            wr_pos_reg   <= '0;
            fill_reg     <= '0;
            dropping_reg <= 1'b0;
            lwt_reg      <= 1'b1;
            idx_reg      <= '0;
            size_reg     <= '0;
            strobe_reg   <= 1'b0;
            bout_reg     <= '0;
            bvalid_reg   <= 1'b0;
            status_reg   <= ST_OK;
            last_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_pos_reg   <= rd_pos_next;
            wr_pos_reg   <= wr_pos_next;
            fill_reg     <= fill_next;
            dropping_reg <= dropping_next;
            lwt_reg      <= lwt_next;
            idx_reg      <= idx_next;
            size_reg     <= size_next;
            strobe_reg   <= strobe_next;
            bout_reg     <= bout_next;
            bvalid_reg   <= bvalid_next;
            status_reg   <= status_next;
            last_reg     <= last_next;
        end
    end

    // Byte ring: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_pos_reg] <= head.data;
        end
        rdata_reg <= mem[raddr];
    end

    assign strobe     = strobe_reg;
    assign byte_out   = bout_reg;
    assign byte_valid = bvalid_reg;
    assign status     = status_reg;
    assign last       = last_reg;

endmodule

`default_nettype wire

// File: hw/rtl/cfwd_checker.sv
// Port-level checks on the command FIFO results, bound to the top level.
`default_nettype none

module cfwd_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           strobe,
    input  wire logic [cfwd_pkg::DATA_W-1:0]    byte_out,
    input  wire logic                           byte_valid,
    input  wire logic [cfwd_pkg::STAT_W-1:0]    status,
    input  wire logic                           last
);
    import cfwd_pkg::*;

    // Quiet result ports between results
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !strobe |-> (!byte_valid && !last && (byte_out == '0)))
        else $error("result ports active without strobe");

    // Only the final result of an item carries a status; earlier ones carry bytes
    a_mid_result: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last) |-> (byte_valid && (status == ST_OK)))
        else $error("non-final result without byte or with status");

    // Empty, full and repeated-terminator results carry no byte
    a_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && ((status == ST_EMPTY) || (status == ST_FULL) ||
                    (status == ST_REPEAT))) |-> (!byte_valid && (byte_out == '0)))
        else $error("byte delivered with a no-data status");

    // A short command ends on its terminator
    a_short_term: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && (status == ST_SHORT)) |-> (byte_valid && (byte_out == '0)))
        else $error("short status without terminator byte");

endmodule

bind command_fifo_with_overflow_drop cfwd_checker u_cfwd_checker (.*);

`default_nettype wire
